[src/gsp_pkg.sv]
package gsp_pkg;

    // Frame geometry
    localparam int FRAME_BITS    = 16;
    localparam int EVENT_BUTTONS = 12;
    localparam int BIT_IDX_W     = $clog2(FRAME_BITS);

    // Field widths
    localparam int HELD_W  = 16;
    localparam int EVENT_W = 12;
    localparam int HALF_W  = 12;
    localparam int LATCH_W = 12;
    localparam int GAP_W   = 20;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 2;

    // Button mask for press/release events
    localparam logic [HELD_W-1:0] EVENT_MASK =
        (EVENT_BUTTONS >= HELD_W) ? {HELD_W{1'b1}}
                                  : HELD_W'((64'd1 << EVENT_BUTTONS) - 64'd1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_ENABLE = 2'd3;

    // Reset values
    localparam logic [LATCH_W-1:0] LATCH_RST = 12'd12;
    localparam logic [HALF_W-1:0]  HALF_RST  = 12'd6;
    localparam logic [GAP_W-1:0]   GAP_RST   = 20'd16000;

    typedef struct packed {
        logic [LATCH_W-1:0] latch_ticks;
        logic [HALF_W-1:0]  half_clock_ticks;
        logic [GAP_W-1:0]   gap_ticks;
        logic               poll_enable;
    } cfg_t;

    // One tick beat from the input register to the core
    typedef struct packed {
        logic valid;
        logic level;
    } tick_t;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_LATCH    = 6'b000010,
        PH_SETTLE   = 6'b000100,
        PH_CLK_LOW  = 6'b001000,
        PH_CLK_HIGH = 6'b010000,
        PH_GAP      = 6'b100000
    } phase_t;

endpackage

[src/gsp_cfg.sv]
module gsp_cfg
    import gsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // Register file, write only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.latch_ticks      <= LATCH_RST;
            cfg_reg.half_clock_ticks <= HALF_RST;
            cfg_reg.gap_ticks        <= GAP_RST;
            cfg_reg.poll_enable      <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LATCH_TICKS: cfg_reg.latch_ticks      <= cfg_data[LATCH_W-1:0];
                REG_HALF_TICKS:  cfg_reg.half_clock_ticks <= cfg_data[HALF_W-1:0];
                REG_GAP_TICKS:   cfg_reg.gap_ticks        <= cfg_data[GAP_W-1:0];
                REG_POLL_ENABLE: cfg_reg.poll_enable      <= cfg_data[0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/gsp_in_stage.sv]
module gsp_in_stage
    import gsp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  data_level,
    input  logic  core_take,
    output tick_t tick
);

    logic valid_reg;
    logic valid_next;
    logic level_reg;
    logic accept;

    // Input register: refills in the same cycle the core takes the beat
    assign in_stall   = valid_reg && !core_take;
    assign accept     = in_valid && !in_stall;
    assign valid_next = accept ? 1'b1 : (valid_reg && !core_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_reg <= data_level;
        end
    end

    assign tick.valid = valid_reg;
    assign tick.level = level_reg;

endmodule

[src/gsp_core.sv]
module gsp_core
    import gsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  tick_t               tick,
    output logic                core_take,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                latch_out,
    output logic                clock_out,
    output logic [HELD_W-1:0]   buttons_held,
    output logic [EVENT_W-1:0]  pressed_mask,
    output logic [EVENT_W-1:0]  released_mask,
    output logic                frame_done
);

    phase_t               phase_reg, phase_next;
    logic [GAP_W-1:0]     timer_reg, timer_next;
    logic [BIT_IDX_W-1:0] bit_reg, bit_next;
    logic [HELD_W-1:0]    shift_reg, shift_next;
    logic [HELD_W-1:0]    held_reg, held_next;
    logic [EVENT_W-1:0]   prev_reg, prev_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 latch_reg, clock_reg, done_reg;
    logic [EVENT_W-1:0]   pmask_reg, rmask_reg;

    phase_t               ph;
    logic [GAP_W-1:0]     tmr;
    logic [BIT_IDX_W-1:0] bi;
    logic [HELD_W-1:0]    sh;
    logic [GAP_W:0]       tmr_inc;
    logic [HELD_W-1:0]    sample_set;
    logic                 last_bit;
    logic [EVENT_W-1:0]   cur;
    logic                 latch_c, clock_c, done_c;
    logic [EVENT_W-1:0]   pmask_c, rmask_c;

    // Take a beat whenever the result register is free or being drained
    assign core_take = tick.valid && (!out_valid_reg || !out_stall);

    // Frame sequencer for one tick
    always_comb
    begin
        ph  = phase_reg;
        tmr = timer_reg;
        bi  = bit_reg;
        sh  = shift_reg;
        if (phase_reg == PH_IDLE && cfg.poll_enable)
        begin
            ph  = PH_LATCH;
            tmr = '0;
            bi  = '0;
            sh  = '0;
        end

        tmr_inc    = {1'b0, tmr} + (GAP_W+1)'(1);
        sample_set = '0;
        if (32'(bi) < HELD_W && !tick.level)
        begin
            sample_set = HELD_W'(1) << bi;
        end
        last_bit = (32'(bi) + 32'd1) >= FRAME_BITS;
        cur      = held_reg[EVENT_W-1:0];

        phase_next = ph;
        timer_next = tmr;
        bit_next   = bi;
        shift_next = sh;
        held_next  = held_reg;
        prev_next  = prev_reg;
        latch_c    = 1'b0;
        clock_c    = 1'b1;
        done_c     = 1'b0;
        pmask_c    = '0;
        rmask_c    = '0;

        case (ph)
            PH_LATCH:
            begin
                latch_c    = 1'b1;
                timer_next = tmr_inc[GAP_W-1:0];
                if (tmr_inc >= (GAP_W+1)'(cfg.latch_ticks))
                begin
                    phase_next = PH_SETTLE;
                    timer_next = '0;
                end
            end
            PH_SETTLE:
            begin
                timer_next = tmr_inc[GAP_W-1:0];
                if (tmr_inc >= (GAP_W+1)'(cfg.half_clock_ticks))
                begin
                    // bit 0 is on the line once latch drops
                    shift_next = sh | sample_set;
                    bit_next   = BIT_IDX_W'(1);
                    phase_next = PH_CLK_LOW;
                    timer_next = '0;
                end
            end
            PH_CLK_LOW:
            begin
                clock_c    = 1'b0;
                timer_next = tmr_inc[GAP_W-1:0];
                if (tmr_inc >= (GAP_W+1)'(cfg.half_clock_ticks))
                begin
                    phase_next = PH_CLK_HIGH;
                    timer_next = '0;
                end
            end
            PH_CLK_HIGH:
            begin
                timer_next = tmr_inc[GAP_W-1:0];
                if (tmr_inc >= (GAP_W+1)'(cfg.half_clock_ticks))
                begin
                    shift_next = sh | sample_set;
                    timer_next = '0;
                    if (last_bit)
                    begin
                        // publish frame and edge-detect event buttons
                        held_next  = sh | sample_set;
                        cur        = held_next[EVENT_W-1:0] & EVENT_MASK[EVENT_W-1:0];
                        pmask_c    = cur & ~prev_reg;
                        rmask_c    = prev_reg & ~cur & EVENT_MASK[EVENT_W-1:0];
                        prev_next  = cur;
                        done_c     = 1'b1;
                        bit_next   = '0;
                        phase_next = (cfg.gap_ticks != '0) ? PH_GAP : PH_IDLE;
                    end
                    else
                    begin
                        bit_next   = bi + BIT_IDX_W'(1);
                        phase_next = PH_CLK_LOW;
                    end
                end
            end
            PH_GAP:
            begin
                timer_next = tmr_inc[GAP_W-1:0];
                if (tmr_inc >= (GAP_W+1)'(cfg.gap_ticks))
                begin
                    phase_next = PH_IDLE;
                    timer_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                timer_next = '0;
            end
        endcase
    end

    // Sequencer state, advances once per taken beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            held_reg  <= '0;
            prev_reg  <= '0;
        end
        else if (core_take)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            held_reg  <= held_next;
            prev_reg  <= prev_next;
        end
    end

    // Result register
    assign out_valid_next = core_take ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_take)
        begin
            latch_reg <= latch_c;
            clock_reg <= clock_c;
            done_reg  <= done_c;
            pmask_reg <= pmask_c;
            rmask_reg <= rmask_c;
        end
    end

    assign out_valid     = out_valid_reg;
    assign latch_out     = latch_reg;
    assign clock_out     = clock_reg;
    assign frame_done    = done_reg;
    assign pressed_mask  = pmask_reg;
    assign released_mask = rmask_reg;

    // held_reg only changes on a completed frame, so it matches the beat in flight
    logic [HELD_W-1:0] held_out_reg;

    always_ff @(posedge clk)
    begin
        if (core_take)
        begin
            held_out_reg <= held_next;
        end
    end

    assign buttons_held = held_out_reg;

    // A button cannot be both pressed and released in one frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (pmask_reg & rmask_reg) == '0)
        else $error("pressed and released masks overlap");

    // Event masks only accompany a completed frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !done_reg) |-> (pmask_reg == '0 && rmask_reg == '0))
        else $error("event mask outside frame_done");

    // Frame completes with latch low and clock high
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> (!latch_reg && clock_reg))
        else $error("bad line levels at frame end");

    // Previous frame tracks published event buttons
    assert property (@(posedge clk) disable iff (!rst_n)
        (core_take && done_c) |=> prev_reg == (held_reg[EVENT_W-1:0] & EVENT_MASK[EVENT_W-1:0]))
        else $error("previous frame out of step with held buttons");

    // Bit counter stays inside the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(bit_reg) < FRAME_BITS)
        else $error("bit index past frame length");

endmodule

[src/gamepad_serial_poller_top.sv]
// Game pad poller: each input beat is one time tick carrying the pad's data
// line level, and each tick yields exactly one result beat with the latch and
// clock levels to drive and the frame status. One tick is taken every clock
// cycle unless the result side stalls, by a single pass of sequencer logic
// between an input register and a result register, and stalls on the result
// side reach the input only once both registers are full. Timing registers
// are counted in ticks; the user must write them only while no beats are in
// flight, and the block itself does not enforce this.
module gamepad_serial_poller_top
    import gsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 data_level,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 latch_out,
    output logic                 clock_out,
    output logic [HELD_W-1:0]    buttons_held,
    output logic [EVENT_W-1:0]   pressed_mask,
    output logic [EVENT_W-1:0]   released_mask,
    output logic                 frame_done
);

    cfg_t  cfg;
    tick_t tick;
    logic  core_take;

    gsp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gsp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_level (data_level),
        .core_take  (core_take),
        .tick       (tick)
    );

    gsp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .tick          (tick),
        .core_take     (core_take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .latch_out     (latch_out),
        .clock_out     (clock_out),
        .buttons_held  (buttons_held),
        .pressed_mask  (pressed_mask),
        .released_mask (released_mask),
        .frame_done    (frame_done)
    );

endmodule

[dv/tb_gamepad_serial_poller_top.sv]
`timescale 1ns / 1ps

module tb_gamepad_serial_poller_top;
    import gsp_pkg::*;

    // One result beat as the poller drives it
    typedef struct packed {
        logic               latch;
        logic               clock;
        logic [HELD_W-1:0]  held;
        logic [EVENT_W-1:0] pressed;
        logic [EVENT_W-1:0] released;
        logic               done;
    } pad_out_t;

    typedef enum logic [0:0] {ROW_TICKS, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        int                  count;
        logic                level;
        bit                  typed;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]    data;
    } script_row_t;

    // Poll disabled: latch low, clock idling high, nothing published
    localparam pad_out_t IDLE_OUT = '{latch: 1'b0, clock: 1'b1, held: '0,
                                      pressed: '0, released: '0, done: 1'b0};
    localparam int HOLD_CYCLES = 300;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 data_level;
    logic                 out_valid;
    logic                 out_stall;
    logic                 latch_out;
    logic                 clock_out;
    logic [HELD_W-1:0]    buttons_held;
    logic [EVENT_W-1:0]   pressed_mask;
    logic [EVENT_W-1:0]   released_mask;
    logic                 frame_done;

    gamepad_serial_poller_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_level    (data_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .latch_out     (latch_out),
        .clock_out     (clock_out),
        .buttons_held  (buttons_held),
        .pressed_mask  (pressed_mask),
        .released_mask (released_mask),
        .frame_done    (frame_done)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor copy of the registers
    logic [LATCH_W-1:0] cfg_latch = LATCH_RST;
    logic [HALF_W-1:0]  cfg_half  = HALF_RST;
    logic [GAP_W-1:0]   cfg_gap   = GAP_RST;
    logic               cfg_poll  = 1'b0;

    // Predictor copy of the poller state
    phase_t             ph          = PH_IDLE;
    logic [GAP_W-1:0]   timer       = '0;
    int                 bit_pos     = 0;
    logic [HELD_W-1:0]  shift_word  = '0;
    logic [HELD_W-1:0]  held_word   = '0;
    logic [EVENT_W-1:0] prev_events = '0;

    pad_out_t pad_ticks_due[$];

    int  fail_count         = 0;
    int  results_checked    = 0;
    int  frames_polled      = 0;
    int  reg_writes         = 0;
    int  ticks_sent         = 0;
    int  input_stall_cycles = 0;
    bit  hold_done          = 1'b0;

    // Advance the poller by one tick and return the levels it drives
    function automatic pad_out_t advance_poller(input logic lvl);
        pad_out_t           r;
        logic [EVENT_W-1:0] cur;
        r = IDLE_OUT;
        r.clock = 1'b1;
        if (ph == PH_IDLE && cfg_poll)
        begin
            ph = PH_LATCH;
            timer = '0;
            shift_word = '0;
            bit_pos = 0;
        end
        case (ph)
            PH_LATCH:
            begin
                r.latch = 1'b1;
                timer = timer + 1'b1;
                if (timer >= cfg_latch)
                begin
                    ph = PH_SETTLE;
                    timer = '0;
                end
            end
            PH_SETTLE:
            begin
                timer = timer + 1'b1;
                if (timer >= cfg_half)
                begin
                    if (!lvl) shift_word[0] = 1'b1;
                    bit_pos = 1;
                    ph = PH_CLK_LOW;
                    timer = '0;
                end
            end
            PH_CLK_LOW:
            begin
                r.clock = 1'b0;
                timer = timer + 1'b1;
                if (timer >= cfg_half)
                begin
                    ph = PH_CLK_HIGH;
                    timer = '0;
                end
            end
            PH_CLK_HIGH:
            begin
                timer = timer + 1'b1;
                if (timer >= cfg_half)
                begin
                    // data is active low
                    if (!lvl) shift_word[bit_pos] = 1'b1;
                    timer = '0;
                    if (bit_pos + 1 >= FRAME_BITS)
                    begin
                        held_word = shift_word;
                        cur = held_word[EVENT_W-1:0] & EVENT_MASK[EVENT_W-1:0];
                        r.pressed = cur & ~prev_events;
                        r.released = prev_events & ~cur;
                        prev_events = cur;
                        r.done = 1'b1;
                        bit_pos = 0;
                        ph = (cfg_gap != '0) ? PH_GAP : PH_IDLE;
                        frames_polled++;
                    end
                    else
                    begin
                        bit_pos++;
                        ph = PH_CLK_LOW;
                    end
                end
            end
            PH_GAP:
            begin
                timer = timer + 1'b1;
                if (timer >= cfg_gap)
                begin
                    ph = PH_IDLE;
                    timer = '0;
                end
            end
            default:
            begin
                ph = PH_IDLE;
                timer = '0;
            end
        endcase
        r.held = held_word;
        return r;
    endfunction

    // Sender gap: mostly none, sometimes short, rarely long
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic script_row_t tick_row(input int count, input logic lvl, input bit typed);
        script_row_t row;
        row.kind = ROW_TICKS;
        row.count = count;
        row.level = lvl;
        row.typed = typed;
        row.idx = '0;
        row.data = '0;
        return row;
    endfunction

    function automatic script_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [CFG_W-1:0] data);
        script_row_t row;
        row.kind = ROW_WRITE;
        row.count = 0;
        row.level = 1'b0;
        row.typed = 1'b0;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    // Offer one tick beat; called and returns at a falling edge
    task automatic send_tick(input logic lvl, input bit typed, input bit quiet);
        pad_out_t p;
        int       gap;
        p = advance_poller(lvl);
        pad_ticks_due.push_back(typed ? IDLE_OUT : p);
        ticks_sent++;
        gap = pick_gap(quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_level <= lvl;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Register write once the pipeline has drained
    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] data);
        in_valid <= 1'b0;
        while (pad_ticks_due.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_LATCH_TICKS: cfg_latch = data[LATCH_W-1:0];
            REG_HALF_TICKS:  cfg_half = data[HALF_W-1:0];
            REG_GAP_TICKS:   cfg_gap = data[GAP_W-1:0];
            REG_POLL_ENABLE: cfg_poll = data[0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        pad_out_t want;
        if (rst_n && in_valid && in_stall) input_stall_cycles++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pad_ticks_due.size() == 0)
            begin
                $error("result beat with no tick pending");
                fail_count++;
            end
            else
            begin
                want = pad_ticks_due.pop_front();
                results_checked++;
                if (latch_out !== want.latch)
                begin
                    $error("latch_out: expected %0d, got %0d", want.latch, latch_out);
                    fail_count++;
                end
                if (clock_out !== want.clock)
                begin
                    $error("clock_out: expected %0d, got %0d", want.clock, clock_out);
                    fail_count++;
                end
                if (buttons_held !== want.held)
                begin
                    $error("buttons_held: expected %h, got %h", want.held, buttons_held);
                    fail_count++;
                end
                if (pressed_mask !== want.pressed)
                begin
                    $error("pressed_mask: expected %h, got %h", want.pressed, pressed_mask);
                    fail_count++;
                end
                if (released_mask !== want.released)
                begin
                    $error("released_mask: expected %h, got %h", want.released,
                           released_mask);
                    fail_count++;
                end
                if (frame_done !== want.done)
                begin
                    $error("frame_done: expected %0d, got %0d", want.done, frame_done);
                    fail_count++;
                end
            end
        end
    end

    // Result side stalls, plus one long hold-off to back up the input
    initial
    begin : result_sink
        int cyc;
        int len;
        bit quiet;
        out_stall = 1'b0;
        cyc = 0;
        quiet = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 256 == 0) quiet = ($urandom_range(0, 99) < 30);
            if (!hold_done && results_checked >= 500 && in_valid)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < 12)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (len) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        script_row_t        bringup[$];
        logic [HELD_W-1:0]  pad_word;
        logic [LATCH_W-1:0] lat;
        logic [HALF_W-1:0]  half;
        logic [GAP_W-1:0]   gapv;
        logic               poll;
        logic               lvl;
        int                 n;
        int                 r;
        int                 phase_no;
        int                 last_frames;
        bit                 special;
        bit                 quiet;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        data_level = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed bring-up: idle after reset, zero timings, all pressed and
        // all released, disable mid-frame, gap, masked high data bits
        bringup.push_back(tick_row(4, 1'b1, 1'b1));
        bringup.push_back(tick_row(3, 1'b0, 1'b1));
        bringup.push_back(write_row(REG_GAP_TICKS, 20'd0));
        bringup.push_back(write_row(REG_LATCH_TICKS, 20'd0));
        bringup.push_back(write_row(REG_HALF_TICKS, 20'd0));
        bringup.push_back(write_row(REG_POLL_ENABLE, 20'd1));
        bringup.push_back(tick_row(32, 1'b0, 1'b0));
        bringup.push_back(tick_row(32, 1'b0, 1'b0));
        bringup.push_back(tick_row(32, 1'b1, 1'b0));
        bringup.push_back(tick_row(10, 1'b0, 1'b0));
        bringup.push_back(write_row(REG_POLL_ENABLE, 20'd0));
        bringup.push_back(tick_row(30, 1'b0, 1'b0));
        bringup.push_back(write_row(REG_GAP_TICKS, 20'd5));
        bringup.push_back(write_row(REG_LATCH_TICKS, 20'd3));
        bringup.push_back(write_row(REG_HALF_TICKS, 20'd2));
        bringup.push_back(write_row(REG_POLL_ENABLE, 20'hFFFFF));
        bringup.push_back(tick_row(60, 1'b1, 1'b0));
        bringup.push_back(tick_row(60, 1'b0, 1'b0));
        bringup.push_back(write_row(REG_LATCH_TICKS, 20'hFF001));
        bringup.push_back(tick_row(40, 1'b1, 1'b0));

        foreach (bringup[i])
        begin
            if (bringup[i].kind == ROW_WRITE)
                program_register(bringup[i].idx, bringup[i].data);
            else
                repeat (bringup[i].count) send_tick(bringup[i].level, bringup[i].typed, 1'b0);
        end

        // Random phases: a pad whose buttons drift from frame to frame,
        // with some line noise; a few phases use the extreme or the reset timings
        pad_word = 16'($urandom);
        phase_no = 0;
        last_frames = frames_polled;
        while (ticks_sent < 1200 && phase_no < 400)
        begin
            special = 1'b1;
            poll = 1'b1;
            case (phase_no)
                1:
                begin
                    lat = 12'd4095; half = 12'd1; gapv = '0; n = 60;
                end
                3:
                begin
                    lat = 12'd1; half = 12'd4095; gapv = '0; n = 60;
                end
                5:
                begin
                    lat = 12'd1; half = 12'd1; gapv = 20'hFFFFF; n = 100;
                end
                7:
                begin
                    lat = LATCH_RST; half = HALF_RST; gapv = GAP_RST; n = 220;
                end
                default:
                begin
                    special = 1'b0;
                    r = $urandom_range(0, 9);
                    lat = (r == 0) ? 12'd0 : (r < 8) ? 12'($urandom_range(1, 4))
                                                     : 12'($urandom_range(5, 20));
                    r = $urandom_range(0, 9);
                    half = (r == 0) ? 12'd0 : (r < 8) ? 12'($urandom_range(1, 3))
                                                      : 12'($urandom_range(4, 6));
                    r = $urandom_range(0, 9);
                    gapv = (r < 4) ? 20'd0 : (r < 8) ? 20'($urandom_range(1, 10))
                                                     : 20'($urandom_range(11, 60));
                    poll = ($urandom_range(0, 6) != 0);
                    n = $urandom_range(60, 160);
                end
            endcase
            program_register(REG_LATCH_TICKS, {8'($urandom), lat});
            program_register(REG_HALF_TICKS, {8'($urandom), half});
            program_register(REG_GAP_TICKS, gapv);
            program_register(REG_POLL_ENABLE, {19'($urandom), poll});
            quiet = special || ($urandom_range(0, 3) == 0);
            repeat (n)
            begin
                if ($urandom_range(0, 99) < 85)
                    lvl = ~pad_word[bit_pos];
                else
                    lvl = 1'($urandom);
                send_tick(lvl, 1'b0, quiet);
                // pad state moves on once a frame is read
                if (frames_polled != last_frames)
                begin
                    last_frames = frames_polled;
                    r = $urandom_range(0, 15);
                    if (r == 0)
                        pad_word = '0;
                    else if (r == 1)
                        pad_word = '1;
                    else if (r < 4)
                        pad_word = 16'($urandom);
                    else
                        repeat ($urandom_range(1, 3)) pad_word[$urandom_range(0, 15)] ^= 1'b1;
                end
            end
            phase_no++;
        end

        // Drain
        in_valid <= 1'b0;
        while (pad_ticks_due.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Run covered %0d ticks in %0d phases, %0d frames read, %0d register writes.",
                 ticks_sent, phase_no, frames_polled, reg_writes);
        $display("Input held off for %0d cycles; %0d result beats checked.",
                 input_stall_cycles, results_checked);
        if (fail_count == 0)
            $display("** gamepad_serial_poller_top: PASSED **");
        else
            $display("** gamepad_serial_poller_top: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(40_000_000);
        $display("** gamepad_serial_poller_top: FAILED **");
        $finish;
    end

endmodule
